// ===== rtl/core/ccld_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ccld_pkg: shared types and constants of the character canvas line drawer
// Holds command codes, character constants and sequencer states.
// ----------------------------------------------------------------------------
package ccld_pkg;

  localparam logic [2:0] MODE_WRITE = 3'd0;
  localparam logic [2:0] MODE_SOFT  = 3'd1;
  localparam logic [2:0] MODE_LINE  = 3'd2;
  localparam logic [2:0] MODE_READ  = 3'd3;
  localparam logic [2:0] MODE_CLEAR = 3'd4;

  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_SPACE = 8'd32;

  typedef enum logic [8:0] {
    ST_INIT  = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_CMD   = 9'b000000100,
    ST_DIV   = 9'b000001000,
    ST_RD    = 9'b000010000,
    ST_WAIT  = 9'b000100000,
    ST_WR    = 9'b001000000,
    ST_CLEAR = 9'b010000000,
    ST_OUT   = 9'b100000000
  } state_t;

endpackage
`default_nettype wire

// ===== rtl/core/char_canvas_line_drawer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// char_canvas_line_drawer: character canvas with a line rasterizer
// Canvas store, one divider and a read-modify-write sequencer.
// ----------------------------------------------------------------------------
// After reset the block fills every cell of the canvas store with dots and
// accepts no item meanwhile. One item is taken at a time. Write, soft write
// and read pass the read and write states of the single-port store; a sloped
// line, for each column: a restoring divider makes one quotient bit per
// cycle, then the row is formed and each point is read and written back.
// A vertical line reads and writes back row by row. Clear walks every cell.
// The result waits in an output register until taken.
module char_canvas_line_drawer #(
  parameter int WIDTH  = 64,
  parameter int HEIGHT = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // mode[2:0], x[8:3], y[13:9], x_end[19:14], y_end[24:20], char_in[32:25]
  input  wire logic [39:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // cell_char[7:0], occupied[8], box_min_x[15:9], box_min_y[21:16],
  // box_max_x[27:22], box_max_y[32:28], out_of_range[33]
  output logic [39:0]      m_tdata
);
  localparam int DEPTH = WIDTH * HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [AW:0] DEPTH_C = AW'(0) + (AW+1)'(DEPTH);
  localparam logic [6:0] MINX_RST = 7'(WIDTH + 1);
  localparam logic [5:0] MINY_RST = 6'(HEIGHT + 1);

  ccld_pkg::state_t state;
  logic [7:0] mem [DEPTH];
  logic [7:0] rdata;
  logic [AW-1:0] addr;
  logic [AW:0] sweep;
  logic       we;
  logic [7:0] wdata;

  logic [2:0] mode;
  logic [5:0] cx, ex, col;
  logic [4:0] cy, ey;
  logic [7:0] ch;
  logic [7:0] rd_char;
  logic occ, bad;
  logic [6:0] min_x;
  logic [5:0] min_y, max_x;
  logic [4:0] max_y;
  logic [5:0] prow;
  logic [6:0] ptr_row;
  logic vert;
  // divider: |dy|*(i-x) / dx
  logic [10:0] num;
  logic [5:0] rem_q, quo;
  logic [6:0] trial;
  logic [3:0] dcnt;
  logic neg;

  logic [5:0] dx;
  logic [4:0] ady;
  assign dx  = ex - cx;
  assign ady = neg ? cy - ey : ey - cy;
  assign trial = {rem_q, num[10]};

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

  logic inside_c;
  assign inside_c = (32'(col) < WIDTH) && (32'(prow) < HEIGHT) && !ptr_row[6];

  always_comb begin
    addr  = AW'(32'(col) * HEIGHT + 32'(prow));
    we    = 1'b0;
    wdata = ch;
    if (state == ccld_pkg::ST_INIT || state == ccld_pkg::ST_CLEAR) begin
      addr  = sweep[AW-1:0];
      we    = 1'b1;
      wdata = (state == ccld_pkg::ST_INIT) ? ccld_pkg::CH_DOT : ccld_pkg::CH_SPACE;
    end else if (state == ccld_pkg::ST_WR) begin
      wdata = (mode == ccld_pkg::MODE_LINE) ? ccld_pkg::CH_DOT : ch;
      we = inside_c && (mode == ccld_pkg::MODE_WRITE ||
                        ((mode == ccld_pkg::MODE_SOFT || mode == ccld_pkg::MODE_LINE) &&
                         rdata == ccld_pkg::CH_SPACE));
    end
  end

  assign s_tready = (state == ccld_pkg::ST_IDLE);
  assign m_tvalid = (state == ccld_pkg::ST_OUT);
  assign m_tdata  = {6'd0, bad, max_y, max_x, min_y, min_x, occ, rd_char};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ccld_pkg::ST_INIT;
      sweep <= '0;
      min_x <= MINX_RST;
      min_y <= MINY_RST;
      max_x <= '0;
      max_y <= '0;
    end else begin
      unique case (state)
        ccld_pkg::ST_INIT, ccld_pkg::ST_CLEAR: begin
          sweep <= sweep + 1'b1;
          if (sweep == DEPTH_C - 1'b1) begin
            state <= (state == ccld_pkg::ST_INIT) ? ccld_pkg::ST_IDLE : ccld_pkg::ST_OUT;
          end
        end
        ccld_pkg::ST_IDLE: if (s_tvalid) begin
          mode <= s_tdata[2:0];
          ch   <= s_tdata[32:25];
          rd_char <= '0; occ <= 1'b0; bad <= 1'b0;
          if (s_tdata[2:0] == ccld_pkg::MODE_LINE && s_tdata[19:14] < s_tdata[8:3]) begin
            cx <= s_tdata[19:14]; cy <= s_tdata[24:20];
            ex <= s_tdata[8:3];   ey <= s_tdata[13:9];
          end else begin
            cx <= s_tdata[8:3];   cy <= s_tdata[13:9];
            ex <= s_tdata[19:14]; ey <= s_tdata[24:20];
          end
          state <= ccld_pkg::ST_CMD;
        end
        ccld_pkg::ST_CMD: begin
          col <= cx; prow <= cy; ptr_row <= {2'b0, cy};
          vert <= (cx == ex);
          neg <= (ey < cy);
          sweep <= '0;
          unique case (mode)
            ccld_pkg::MODE_WRITE, ccld_pkg::MODE_SOFT, ccld_pkg::MODE_READ:
              state <= ccld_pkg::ST_RD;
            ccld_pkg::MODE_LINE: begin
              if (cx == ex) state <= (cy < ey) ? ccld_pkg::ST_RD : ccld_pkg::ST_OUT;
              else state <= ccld_pkg::ST_RD;
            end
            ccld_pkg::MODE_CLEAR: state <= ccld_pkg::ST_CLEAR;
            default: state <= ccld_pkg::ST_OUT;
          endcase
        end
        ccld_pkg::ST_DIV: begin
          if (trial >= {1'b0, dx}) begin
            rem_q <= 6'(trial - {1'b0, dx}); quo <= {quo[4:0], 1'b1};
          end else begin
            rem_q <= trial[5:0]; quo <= {quo[4:0], 1'b0};
          end
          num <= {num[9:0], 1'b0};
          dcnt <= dcnt - 1'b1;
          if (dcnt == 4'd0) state <= ccld_pkg::ST_WAIT;
        end
        ccld_pkg::ST_WAIT: begin
          ptr_row <= neg ? 7'({2'b0, cy}) - 7'(quo) : 7'({2'b0, cy}) + 7'(quo);
          prow <= neg ? cy - 5'(quo) : cy + 5'(quo);
          state <= ccld_pkg::ST_RD;
        end
        ccld_pkg::ST_RD: state <= ccld_pkg::ST_WR;
        ccld_pkg::ST_WR: begin
          if (!inside_c) bad <= 1'b1;
          else if (we) begin
            if ({1'b0, col} < min_x) min_x <= {1'b0, col};
            if (col > max_x) max_x <= col;
            if ({1'b0, prow[4:0]} < min_y) min_y <= {1'b0, prow[4:0]};
            if (prow[4:0] > max_y) max_y <= prow[4:0];
          end
          if (mode == ccld_pkg::MODE_READ && inside_c) begin
            rd_char <= rdata;
            occ <= rdata != ccld_pkg::CH_SPACE && rdata != ccld_pkg::CH_DOT;
          end
          state <= ccld_pkg::ST_OUT;
          if (mode == ccld_pkg::MODE_LINE) begin
            if (vert) begin
              if (prow + 1'b1 < 6'(ey)) begin
                prow <= prow + 1'b1; ptr_row <= ptr_row + 1'b1;
                state <= ccld_pkg::ST_RD;
              end
            end else if (col + 1'b1 < ex) begin
              col <= col + 1'b1;
              num <= 11'(ady) * 11'(col + 1'b1 - cx);
              rem_q <= '0; quo <= '0; dcnt <= 4'd10;
              state <= ccld_pkg::ST_DIV;
            end
          end
        end
        ccld_pkg::ST_OUT: if (m_tready) state <= ccld_pkg::ST_IDLE;
        default: state <= ccld_pkg::ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_one_side: assert property (@(posedge clk) disable iff (rst) !(s_tready && m_tvalid))
    else $error("ready and valid together");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("result dropped");
  a_box: assert property (@(posedge clk) disable iff (rst)
    (max_x != 0) |-> (min_x <= 7'(max_x))) else $error("box inverted");
`endif

endmodule
`default_nettype wire
